// ===== src/bru_pkg.sv =====
// Shared types and constants for the ByteRun1 bitplane body unpacker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bru_pkg;

  // Upper bounds of the geometry registers.
  localparam int MAX_ROW_BYTES = 128;
  localparam int MAX_ROWS      = 1024;
  localparam int MAX_PLANES    = 8;

  // Configuration port.
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMPRESSION = 2'd3;

  // Status codes carried with each result.
  localparam logic [1:0] STAT_BUSY     = 2'd0;
  localparam logic [1:0] STAT_DONE     = 2'd1;
  localparam logic [1:0] STAT_SHORT    = 2'd2;
  localparam logic [1:0] STAT_OVERRUN  = 2'd3;

  // Control byte that ByteRun1 defines as a no-operation.
  localparam logic [7:0] CTRL_SKIP = 8'h80;

  typedef enum logic [1:0] {
    MODE_CTRL = 2'd0,
    MODE_LIT  = 2'd1,
    MODE_REP  = 2'd2
  } mode_t;

  // Effective geometry, already clamped to the legal ranges.
  typedef struct packed {
    logic [7:0]  row_bytes;
    logic [10:0] row_count;
    logic [3:0]  plane_count;
    logic        rle;
  } cfg_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       first;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       run_valid;
    logic [7:0] data;
    logic [7:0] repeat_count;
    logic [2:0] plane_index;
    logic [9:0] row_index;
    logic [6:0] column_start;
    logic [1:0] status;
  } result_t;

endpackage

`default_nettype wire

// ===== src/byterun1_bitplane_unpacker.sv =====
// Top level of the ByteRun1 / raw bitplane body unpacker.
// Depends on bru_pkg, bru_cfg_regs and bru_decode.
//
// The block takes the body of an interleaved bitplane image one byte per
// input beat (body_byte with first_of_body and last_of_body) and returns
// write runs on the output channel: data, repeat_count and the plane, row
// and column where the run starts, together with a status code.
// Control bytes, skip bytes and bytes after completion or an error give no
// output beat; a byte that only changes the status gives a beat with
// run_valid low and all address fields zero.
// Each byte passes an input register, the decoder logic and an output
// register. One byte is accepted in every cycle while the output register
// can drain; the decoder state is registered with each decoded byte.
// When the receiver stalls, the output register holds its beat, the input
// register holds one more byte, and in_ready falls until out_ready returns.
// Reset restores the geometry registers to 40 bytes per row, 256 rows,
// 5 planes and ByteRun1 coding, and empties both registers. Geometry is
// written through cfg_write, cfg_index and cfg_data while no byte is in
// flight; zero values act as one and values above the limits are clamped.
`timescale 1ns / 1ps
`default_nettype none

module byterun1_bitplane_unpacker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration writes.
  input  wire logic                          cfg_write,
  input  wire logic [bru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bru_pkg::CFG_W-1:0]     cfg_data,
  // Body byte channel.
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    body_byte,
  input  wire logic                          first_of_body,
  input  wire logic                          last_of_body,
  // Write run channel.
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               run_valid,
  output logic [7:0]                         data,
  output logic [7:0]                         repeat_count,
  output logic [2:0]                         plane_index,
  output logic [9:0]                         row_index,
  output logic [6:0]                         column_start,
  output logic [1:0]                         status
);
  import bru_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_item_valid;
  logic    advance;
  logic    step;
  logic    emit;
  result_t result;
  result_t out_beat;

  bru_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The output register can take a new beat when it is empty or being
  // drained in this cycle; the byte in the input register is then decoded.
  assign advance  = !out_valid || out_ready;
  assign step     = in_item_valid && advance;
  assign in_ready = !in_item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_item_valid <= 1'b1;
    end else if (step) begin
      in_item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.body_byte <= body_byte;
      in_item.first     <= first_of_body;
      in_item.last      <= last_of_body;
    end
  end

  bru_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .cfg    (cfg),
    .emit   (emit),
    .result (result)
  );

  // Output register: a decoded byte with something to report loads it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_beat <= result;
    end
  end

  assign run_valid    = out_beat.run_valid;
  assign data         = out_beat.data;
  assign repeat_count = out_beat.repeat_count;
  assign plane_index  = out_beat.plane_index;
  assign row_index    = out_beat.row_index;
  assign column_start = out_beat.column_start;
  assign status       = out_beat.status;

endmodule

`default_nettype wire

// ===== src/bru_cfg_regs.sv =====
// Configuration registers of the unpacker, stored already clamped.
// Depends on bru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bru_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [bru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bru_pkg::CFG_W-1:0]     cfg_data,
  output bru_pkg::cfg_t                      cfg
);
  import bru_pkg::*;

  logic [7:0] rb_in;
  logic [10:0] rows_in;
  logic [3:0] planes_in;

  // A zero acts as one and anything above the bound acts as the bound.
  always_comb begin
    rb_in = cfg_data[7:0];
    if (rb_in == 8'd0) begin
      rb_in = 8'd1;
    end else if (rb_in > 8'(MAX_ROW_BYTES)) begin
      rb_in = 8'(MAX_ROW_BYTES);
    end
    rows_in = cfg_data[10:0];
    if (rows_in == 11'd0) begin
      rows_in = 11'd1;
    end else if (rows_in > 11'(MAX_ROWS)) begin
      rows_in = 11'(MAX_ROWS);
    end
    planes_in = cfg_data[3:0];
    if (planes_in == 4'd0) begin
      planes_in = 4'd1;
    end else if (planes_in > 4'(MAX_PLANES)) begin
      planes_in = 4'(MAX_PLANES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_bytes   <= 8'd40;
      cfg.row_count   <= 11'd256;
      cfg.plane_count <= 4'd5;
      cfg.rle         <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_BYTES:   cfg.row_bytes   <= rb_in;
        REG_ROW_COUNT:   cfg.row_count   <= rows_in;
        REG_PLANE_COUNT: cfg.plane_count <= planes_in;
        REG_COMPRESSION: cfg.rle         <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/bru_decode.sv =====
// ByteRun1 decoder state and position counters; turns one body byte into
// at most one write run. Depends on bru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bru_decode (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  bru_pkg::item_t item,
  input  bru_pkg::cfg_t  cfg,
  output logic           emit,
  output bru_pkg::result_t result
);
  import bru_pkg::*;

  mode_t      mode, mode_next, mode_c;
  logic [7:0] literal_left, literal_left_next, lit_c;
  logic [7:0] repeat_pending, repeat_pending_next, rep_c;
  logic [9:0] row_position, row_position_next, row_c;
  logic [2:0] plane_position, plane_position_next, plane_c;
  logic [6:0] column_position, column_position_next, col_c;
  logic [1:0] final_status, final_status_next, fs_c;

  logic       wr;
  logic [7:0] cnt;
  logic [7:0] run_len;
  logic [8:0] col_sum;
  logic [3:0] plane_inc;
  logic [10:0] row_inc;
  logic [1:0] fs_dec;
  logic [7:0] lit_dec;

  // A first byte restarts the body before it is decoded.
  always_comb begin
    if (item.first) begin
      mode_c  = MODE_CTRL;
      lit_c   = 8'd0;
      rep_c   = 8'd0;
      row_c   = 10'd0;
      plane_c = 3'd0;
      col_c   = 7'd0;
      fs_c    = STAT_BUSY;
    end else begin
      mode_c  = mode;
      lit_c   = literal_left;
      rep_c   = repeat_pending;
      row_c   = row_position;
      plane_c = plane_position;
      col_c   = column_position;
      fs_c    = final_status;
    end
  end

  // Length announced by a control byte: n+1 for a literal, 257-n for a repeat.
  assign run_len = item.body_byte[7] ? 8'(~item.body_byte) + 8'd2
                                     : item.body_byte + 8'd1;
  assign lit_dec = (lit_c != 8'd0) ? lit_c - 8'd1 : 8'd0;

  // Next state of the decode mode and its counters.
  always_comb begin
    mode_next           = mode_c;
    literal_left_next   = lit_c;
    repeat_pending_next = rep_c;
    fs_dec              = fs_c;
    wr                  = 1'b0;
    cnt                 = 8'd0;
    if (fs_c == STAT_BUSY) begin
      if (!cfg.rle) begin
        wr  = 1'b1;
        cnt = 8'd1;
      end else begin
        unique case (mode_c)
          MODE_LIT: begin
            wr                = 1'b1;
            cnt               = 8'd1;
            literal_left_next = lit_dec;
            if (lit_dec == 8'd0) begin
              mode_next = MODE_CTRL;
            end
          end
          MODE_REP: begin
            wr                  = 1'b1;
            cnt                 = rep_c;
            repeat_pending_next = 8'd0;
            mode_next           = MODE_CTRL;
          end
          default: begin
            mode_next = MODE_CTRL;
            if (item.body_byte != CTRL_SKIP) begin
              if ({2'b00, col_c} + {1'b0, run_len} > {1'b0, cfg.row_bytes}) begin
                fs_dec = STAT_OVERRUN;
              end else if (!item.body_byte[7]) begin
                literal_left_next = run_len;
                mode_next         = MODE_LIT;
              end else begin
                repeat_pending_next = run_len;
                mode_next           = MODE_REP;
              end
            end
          end
        endcase
      end
    end
  end

  // Position counters: column, then plane, then row.
  assign col_sum   = {2'b00, col_c} + {1'b0, cnt};
  assign plane_inc = {1'b0, plane_c} + 4'd1;
  assign row_inc   = {1'b0, row_c} + 11'd1;

  always_comb begin
    column_position_next = col_c;
    plane_position_next  = plane_c;
    row_position_next    = row_c;
    final_status_next    = fs_dec;
    if (wr) begin
      if (col_sum >= {1'b0, cfg.row_bytes}) begin
        column_position_next = 7'd0;
        if (plane_inc >= cfg.plane_count) begin
          plane_position_next = 3'd0;
          if (row_inc >= cfg.row_count) begin
            row_position_next = 10'd0;
            final_status_next = STAT_DONE;
          end else begin
            row_position_next = row_inc[9:0];
          end
        end else begin
          plane_position_next = plane_inc[2:0];
        end
      end else begin
        column_position_next = col_sum[6:0];
      end
    end
    if (final_status_next == STAT_BUSY && item.last && fs_c == STAT_BUSY) begin
      final_status_next = STAT_SHORT;
    end
  end

  // Result of this byte.
  always_comb begin
    emit                = wr || (fs_c == STAT_BUSY && final_status_next != STAT_BUSY);
    result.run_valid    = wr;
    result.data         = wr ? item.body_byte : 8'd0;
    result.repeat_count = cnt;
    result.plane_index  = wr ? plane_c : 3'd0;
    result.row_index    = wr ? row_c : 10'd0;
    result.column_start = wr ? col_c : 7'd0;
    result.status       = final_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_CTRL;
      literal_left    <= 8'd0;
      repeat_pending  <= 8'd0;
      row_position    <= 10'd0;
      plane_position  <= 3'd0;
      column_position <= 7'd0;
      final_status    <= STAT_BUSY;
    end else if (step) begin
      mode            <= mode_next;
      literal_left    <= literal_left_next;
      repeat_pending  <= repeat_pending_next;
      row_position    <= row_position_next;
      plane_position  <= plane_position_next;
      column_position <= column_position_next;
      final_status    <= final_status_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/bru_checker.sv =====
// Port-level checks for the unpacker, bound to its top level.
// Depends on bru_pkg and byterun1_bitplane_unpacker.
`timescale 1ns / 1ps
`default_nettype none

module bru_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       run_valid,
  input wire logic [7:0] data,
  input wire logic [7:0] repeat_count,
  input wire logic [2:0] plane_index,
  input wire logic [9:0] row_index,
  input wire logic [6:0] column_start,
  input wire logic [1:0] status
);
  import bru_pkg::*;

  // A stalled output beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data) && $stable(status)
      && $stable(repeat_count) && $stable(column_start))
    else $error("stalled output beat changed");

  // A beat without a write only reports a status change, with zero fields.
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_valid |-> status != STAT_BUSY && data == 8'd0
      && repeat_count == 8'd0 && plane_index == 3'd0 && row_index == 10'd0
      && column_start == 7'd0)
    else $error("status-only beat carries write fields");

  // A write run never passes the end of the longest row.
  a_run_fits: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_valid |-> repeat_count != 8'd0
      && ({2'b00, column_start} + {1'b0, repeat_count}) <= 9'(MAX_ROW_BYTES))
    else $error("write run out of row range");

  // With the output register empty the block always takes a byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output beat present after reset");

endmodule

bind byterun1_bitplane_unpacker bru_checker u_bru_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the ByteRun1 / raw bitplane body unpacker.
// Depends only on bru_pkg and the byterun1_bitplane_unpacker RTL.
`timescale 1ns / 1ps

module testbench;
  import bru_pkg::*;

  // Bytes that give no result may still be in the pipeline after the last
  // predicted run has arrived; this margin covers them.
  localparam int SETTLE_CYCLES  = 6;
  // Cycles without any beat on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;
  // Longest body that the random generators produce.
  localparam int BODY_CAP       = 150;
  // Mismatch lines beyond this number are counted but not printed.
  localparam int REPORT_CAP     = 40;

  // Every input of the block has a known value from time zero.
  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_write     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = REG_ROW_BYTES;
  logic [CFG_W-1:0]     cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic [7:0]           body_byte     = 8'h00;
  logic                 first_of_body = 1'b0;
  logic                 last_of_body  = 1'b0;
  logic                 out_ready     = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 run_valid;
  logic [7:0]           data;
  logic [7:0]           repeat_count;
  logic [2:0]           plane_index;
  logic [9:0]           row_index;
  logic [6:0]           column_start;
  logic [1:0]           status;

  byterun1_bitplane_unpacker i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .body_byte    (body_byte),
    .first_of_body(first_of_body),
    .last_of_body (last_of_body),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .run_valid    (run_valid),
    .data         (data),
    .repeat_count (repeat_count),
    .plane_index  (plane_index),
    .row_index    (row_index),
    .column_start (column_start),
    .status       (status)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow of the geometry registers, held as written (already masked to
  // the register widths). Clamping happens where the values are used.
  // ---------------------------------------------------------------------
  int unsigned geom_row_bytes = 40;
  int unsigned geom_row_count = 256;
  int unsigned geom_planes    = 5;
  bit          geom_rle       = 1'b1;

  // Decoder state of the predictor.
  mode_t       dec_mode  = MODE_CTRL;
  int unsigned lit_left  = 0;
  int unsigned rep_left  = 0;
  int unsigned row_pos   = 0;
  int unsigned plane_pos = 0;
  int unsigned col_pos   = 0;
  logic [1:0]  img_status = STAT_BUSY;

  // Write runs that the block still owes, oldest first.
  result_t runs_due[$];
  result_t oldest_run;

  // Bookkeeping.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned bytes_decoded  = 0;
  int unsigned runs_seen      = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // State of the body currently being generated.
  bit          opening_byte = 1'b0;
  bit          body_over    = 1'b0;
  int unsigned body_len     = 0;
  int unsigned body_stop    = 0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Zero acts as one, and anything above the hardware limit is clamped.
  function automatic int unsigned clamp_geom(int unsigned value, int unsigned limit);
    if (value == 0) return 1;
    return (value > limit) ? limit : value;
  endfunction

  function automatic void restart_image();
    dec_mode   = MODE_CTRL;
    lit_left   = 0;
    rep_left   = 0;
    row_pos    = 0;
    plane_pos  = 0;
    col_pos    = 0;
    img_status = STAT_BUSY;
  endfunction

  // Moves the write position on by a run. Reaching the end of a plane row
  // steps to the next plane, then to the next row, and past the last row
  // the image is complete.
  function automatic void advance_position(int unsigned columns);
    col_pos += columns;
    if (col_pos >= clamp_geom(geom_row_bytes, MAX_ROW_BYTES)) begin
      col_pos = 0;
      plane_pos++;
      if (plane_pos >= clamp_geom(geom_planes, MAX_PLANES)) begin
        plane_pos = 0;
        row_pos++;
        if (row_pos >= clamp_geom(geom_row_count, MAX_ROWS)) begin
          row_pos    = 0;
          img_status = STAT_DONE;
        end
      end
    end
  endfunction

  // Decodes one accepted body byte and queues the write run or status
  // beat it should produce, if any.
  function automatic void decode_body_byte(logic [7:0] value, logic first, logic last);
    result_t     run;
    logic        writes;
    int unsigned span;
    int unsigned width;
    int unsigned n;

    run    = '0;
    writes = 1'b0;
    span   = 0;
    if (first) restart_image();
    // Once the image is complete or broken, bytes are ignored.
    if (img_status != STAT_BUSY) return;
    bytes_decoded++;

    width = clamp_geom(geom_row_bytes, MAX_ROW_BYTES);
    if (!geom_rle) begin
      writes = 1'b1;
      span   = 1;
    end else if (dec_mode == MODE_LIT) begin
      writes = 1'b1;
      span   = 1;
      if (lit_left > 0) lit_left--;
      if (lit_left == 0) dec_mode = MODE_CTRL;
    end else if (dec_mode == MODE_REP) begin
      writes   = 1'b1;
      span     = rep_left;
      rep_left = 0;
      dec_mode = MODE_CTRL;
    end else begin
      // Control byte: 0..127 opens a literal of n+1 bytes, 129..255 a
      // repeat of 257-n, and the skip code does nothing at all.
      dec_mode = MODE_CTRL;
      if (value != CTRL_SKIP) begin
        n = (value < 8'd128) ? value + 1 : 257 - value;
        if (col_pos + n > width) begin
          img_status = STAT_OVERRUN;
        end else if (value < 8'd128) begin
          lit_left = n;
          dec_mode = MODE_LIT;
        end else begin
          rep_left = n;
          dec_mode = MODE_REP;
        end
      end
    end

    if (writes) begin
      run.run_valid    = 1'b1;
      run.data         = value;
      run.repeat_count = span[7:0];
      run.plane_index  = plane_pos[2:0];
      run.row_index    = row_pos[9:0];
      run.column_start = col_pos[6:0];
      advance_position(span);
    end
    // A body that ends early is flagged after any write of its last byte.
    if (img_status == STAT_BUSY && last) img_status = STAT_SHORT;
    if (!writes && img_status == STAT_BUSY) return;
    run.status = img_status;
    runs_due.push_back(run);
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic flag_mismatch(string what);
    if (mismatch_count < REPORT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic compare_field(string field, logic [9:0] got, logic [9:0] want);
    if (got !== want)
      flag_mismatch($sformatf("write beat %0d: %s is 0x%0h, predicted 0x%0h",
                              runs_seen, field, got, want));
  endtask

  // Every accepted output beat is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (runs_due.size() == 0) begin
        flag_mismatch("output beat arrived with no write run predicted");
      end else begin
        oldest_run = runs_due.pop_front();
        compare_field("run_valid",    10'(run_valid),    10'(oldest_run.run_valid));
        compare_field("data",         10'(data),         10'(oldest_run.data));
        compare_field("repeat_count", 10'(repeat_count), 10'(oldest_run.repeat_count));
        compare_field("plane_index",  10'(plane_index),  10'(oldest_run.plane_index));
        compare_field("row_index",    row_index,         oldest_run.row_index);
        compare_field("column_start", 10'(column_start), 10'(oldest_run.column_start));
        compare_field("status",       10'(status),       10'(oldest_run.status));
      end
      runs_seen++;
    end
  end

  // The receiver stalls at random; the rate is changed by the test phases.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Gives up when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] timeout: no beat on either channel for %0d cycles, %0d runs still due",
               $realtime, quiet_cycles, runs_due.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Presents one body byte, possibly after a random gap, and holds it until
  // the block takes it. The prediction is made at the accepting edge.
  task automatic send_byte(logic [7:0] value, logic first, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    body_byte     <= value;
    first_of_body <= first;
    last_of_body  <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    decode_body_byte(value, first, last);
  endtask

  // Stops sending and waits for every predicted run, then lets the
  // pipeline empty of bytes that produce nothing.
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (runs_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all four geometry registers while the block is idle.
  task automatic configure(int unsigned rb, int unsigned rows, int unsigned planes, bit rle);
    wait_for_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_ROW_BYTES;
    cfg_data  <= rb[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= rows[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_PLANE_COUNT;
    cfg_data  <= planes[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_COMPRESSION;
    cfg_data  <= CFG_W'(rle);
    @(negedge clk);
    cfg_write <= 1'b0;
    geom_row_bytes = rb & 32'hFF;
    geom_row_count = rows & 32'h7FF;
    geom_planes    = planes & 32'hF;
    geom_rle       = rle;
  endtask

  // A body either runs to the end of the image or is cut short at a random
  // byte; it is never longer than the cap.
  task automatic start_body(int unsigned max_len);
    opening_byte = 1'b1;
    body_over    = 1'b0;
    body_len     = 0;
    body_stop    = ($urandom_range(3) == 0) ? $urandom_range(1, max_len) : max_len;
  endtask

  task automatic emit(logic [7:0] value, bit image_end);
    logic is_last;
    is_last = image_end || (body_len + 1 >= body_stop);
    send_byte(value, opening_byte, is_last);
    opening_byte = 1'b0;
    body_len++;
    if (is_last) body_over = 1'b1;
  endtask

  // Bytes after the end of a body are ignored by the block.
  task automatic send_trailing();
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
    end
  endtask

  // A well-formed ByteRun1 body: literals and repeats sized to the room
  // left in the current plane row, with the odd skip code, and now and
  // then a run too long for the row.
  task automatic send_rle_body(int unsigned max_len);
    int unsigned width;
    int unsigned segments;
    int unsigned col;
    int unsigned room;
    int unsigned limit;
    int unsigned n;
    int unsigned k;
    int unsigned i;

    width    = clamp_geom(geom_row_bytes, MAX_ROW_BYTES);
    segments = clamp_geom(geom_row_count, MAX_ROWS) * clamp_geom(geom_planes, MAX_PLANES);
    col      = 0;
    start_body(max_len);
    while (!body_over) begin
      room = width - col;
      k    = $urandom_range(99);
      if (k < 4) begin
        emit(CTRL_SKIP, 1'b0);
      end else if (k < 7 && room < 128) begin
        n = $urandom_range(room + 1, 128);
        emit($urandom_range(1) ? 8'(n - 1) : 8'(257 - n), 1'b0);
        body_over = 1'b1;
      end else begin
        limit = (room < 128) ? room : 128;
        if (limit == 1 || k < 50) begin
          n = ($urandom_range(3) == 0) ? $urandom_range(1, limit)
                                       : $urandom_range(1, (limit < 6) ? limit : 6);
          emit(8'(n - 1), 1'b0);
          for (i = 0; i < n && !body_over; i++)
            emit(8'($urandom_range(255)),
                 (i == n - 1) && (col + n == width) && (segments == 1));
        end else begin
          n = ($urandom_range(3) == 0) ? limit : $urandom_range(2, limit);
          emit(8'(257 - n), 1'b0);
          if (!body_over)
            emit(8'($urandom_range(255)), (col + n == width) && (segments == 1));
        end
        col += n;
        if (col == width) begin
          col = 0;
          segments--;
        end
      end
    end
    send_trailing();
  endtask

  // A raw body: one byte per column until the image is full or cut short.
  task automatic send_raw_body(int unsigned max_len);
    int unsigned total;
    int unsigned k;

    total = clamp_geom(geom_row_bytes, MAX_ROW_BYTES) * clamp_geom(geom_row_count, MAX_ROWS)
            * clamp_geom(geom_planes, MAX_PLANES);
    k = 0;
    start_body(max_len);
    while (!body_over) begin
      emit(8'($urandom_range(255)), k + 1 == total);
      k++;
    end
    send_trailing();
  endtask

  // Random bytes with random framing. Without an opening restart this
  // carries on from whatever state the previous body left behind, under
  // the geometry just written.
  task automatic send_noise(bit fresh);
    int unsigned n;
    int unsigned i;

    n = $urandom_range(1, 30);
    for (i = 0; i < n; i++)
      send_byte(8'($urandom_range(255)), (i == 0) ? fresh : ($urandom_range(19) == 0),
                $urandom_range(9) == 0);
  endtask

  // Mostly small images so that bodies complete, with the limits and the
  // degenerate register values mixed in.
  task automatic pick_geometry();
    int unsigned rb;
    int unsigned rows;
    int unsigned planes;
    int unsigned k;

    k = $urandom_range(9);
    if (k < 7)       rb = 2 * $urandom_range(1, 8);
    else if (k == 7) rb = 128;
    else if (k == 8) rb = $urandom_range(0, 7) * 2 + 1;
    else             rb = $urandom_range(255);
    k = $urandom_range(9);
    if (k < 7)       rows = $urandom_range(1, 3);
    else if (k == 7) rows = 0;
    else if (k == 8) rows = $urandom_range(1024, 2047);
    else             rows = $urandom_range(1, 8);
    k = $urandom_range(9);
    if (k < 6)       planes = $urandom_range(1, 4);
    else if (k < 8)  planes = $urandom_range(5, 8);
    else if (k == 8) planes = 0;
    else             planes = $urandom_range(9, 15);
    configure(rb, rows, planes, $urandom_range(3) != 0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset geometry (40 bytes, 256 rows, 5 planes, ByteRun1): literals,
  // repeats, the skip code, runs too long for the row and a short body.
  task automatic test_byterun1_codes();
    send_byte(8'h00, 1'b1, 1'b0);     // literal of one byte
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);     // repeat twice
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(CTRL_SKIP, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);     // literal of two bytes
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'hDB, 1'b0, 1'b0);     // 38 repeats from column 5 overrun the row
    send_byte(8'h12, 1'b0, 1'b0);     // ignored after the error
    send_byte(8'hD9, 1'b1, 1'b0);     // 40 repeats fill plane 0 exactly
    send_byte(8'h33, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);     // longest literal, too long here
    send_byte(8'h81, 1'b1, 1'b0);     // longest repeat, too long here
    send_byte(8'h00, 1'b1, 1'b1);     // body ends on a control byte
  endtask

  // Raw copy of a tiny image: completion wins over a last byte that fills
  // it, trailing bytes are ignored, and a one-byte body is too short.
  task automatic test_raw_copy();
    configure(2, 1, 2, 1'b0);
    send_byte(8'h0F, 1'b1, 1'b0);
    send_byte(8'hF0, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b1);
    send_byte(8'h99, 1'b0, 1'b0);
    send_byte(8'h66, 1'b1, 1'b1);
  endtask

  // Zero registers act as one; oversized ones clamp to the limits, which
  // lets the longest repeat fill a whole 128-byte row.
  task automatic test_degenerate_geometry();
    configure(0, 0, 0, 1'b0);
    send_byte(8'hAA, 1'b1, 1'b0);
    configure(255, 2047, 15, 1'b1);
    send_byte(8'h81, 1'b1, 1'b0);
    send_byte(8'h77, 1'b0, 1'b1);
  endtask

  // Registers changed in the middle of a body: raw mode interrupts a
  // literal, ByteRun1 then resumes it, and a narrower row moves the write
  // on to the next plane.
  task automatic test_midbody_changes();
    configure(8, 2, 2, 1'b1);
    send_byte(8'h02, 1'b1, 1'b0);
    send_byte(8'h11, 1'b0, 1'b0);
    configure(8, 2, 2, 1'b0);
    send_byte(8'h22, 1'b0, 1'b0);
    configure(8, 2, 2, 1'b1);
    send_byte(8'h44, 1'b0, 1'b0);
    configure(2, 2, 2, 1'b1);
    send_byte(8'h55, 1'b0, 1'b1);
  endtask

  // Random bodies under random geometry until the phase has sent its share
  // of bytes. Each body picks whether the two sides idle, so there are
  // quiet stretches within every phase.
  task automatic test_random_bodies(int unsigned idle_pct, int unsigned stall_pct,
                                    int unsigned quota);
    int unsigned goal;
    int unsigned kind;
    int unsigned cap;

    goal = bytes_sent + quota;
    while (bytes_sent < goal) begin
      pick_geometry();
      repeat ($urandom_range(1, 3)) begin
        if (bytes_sent < goal) begin
          // Bodies are kept within what is left of the phase's share.
          cap = goal - bytes_sent;
          if (cap > BODY_CAP) cap = BODY_CAP;
          send_idle_pct  = ($urandom_range(3) == 0) ? 0 : idle_pct;
          recv_stall_pct = ($urandom_range(3) == 0) ? 0 : stall_pct;
          kind = $urandom_range(9);
          if (kind == 0)      send_noise($urandom_range(1));
          else if (!geom_rle) send_raw_body(cap);
          else                send_rle_body(cap);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    restart_image();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_byterun1_codes();
    test_raw_copy();
    test_degenerate_geometry();
    test_midbody_changes();

    test_random_bodies(0, 0, 285);
    test_random_bodies(54, 0, 285);
    test_random_bodies(0, 54, 285);
    test_random_bodies(35, 35, 285);

    wait_for_idle();
    if (runs_due.size() != 0)
      flag_mismatch($sformatf("%0d predicted runs never arrived", runs_due.size()));

    $display("Decoded %0d body bytes and checked %0d output beats across raw and ByteRun1",
             bytes_decoded, runs_seen);
    $display("bodies, clamped and zero geometry, and mid-body register changes.");
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
